// ===== hw/rtl/kop_pkg.sv =====
// shared types, constants and tables for the kepler orbit propagator
package kop_pkg;

  // fixed formats
  localparam int ANGLE_BITS     = 32;
  localparam int CORDIC_STEPS   = 32;
  localparam int ECC_W          = 16;
  localparam int SMA_W          = 24;
  localparam int MMS_W          = 32;
  localparam int POS_W          = 26;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;

  // arithmetic constants
  localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;
  localparam logic [30:0] INV_TWO_PI_Q32  = 31'd683565276;
  localparam logic [15:0] ECC_MAX         = 16'd64880;

  // register reset values
  localparam logic [ECC_W-1:0] ECC_RESET = 16'd6554;
  localparam logic [SMA_W-1:0] SMA_RESET = 24'd160000;
  localparam logic [MMS_W-1:0] MMS_RESET = 32'd431568;

  // parameter defaults
  localparam int MAX_ITERATIONS_DEF     = 100;
  localparam int CONVERGE_TOLERANCE_DEF = 683;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECC = 2'd0,
    CFG_SMA = 2'd1,
    CFG_MMS = 2'd2
  } cfg_idx_t;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_COR_GO,
    S_COR_WAIT,
    S_MUL_ES,
    S_MUL_INV,
    S_ESIN,
    S_DELTA,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_UPDATE,
    S_FIN_A,
    S_SQ_GO,
    S_SQ_WAIT,
    S_FIN_T,
    S_FIN_TR,
    S_FIN_Y,
    S_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic cor_start;
    logic mul_es;
    logic mul_inv;
    logic esin;
    logic delta;
    logic div_start;
    logic update;
    logic fin_a;
    logic sq_start;
    logic fin_t;
    logic fin_tr;
    logic fin_y;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cor_busy;
    logic div_busy;
    logic sq_busy;
    logic converged;
    logic out_busy;
  } dp_sts_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/kop_tick_if.sv =====
// tick input channel
interface kop_tick_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

// ===== hw/rtl/kop_result_if.sv =====
// position result channel
interface kop_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [kop_pkg::POS_W-1:0]    x_pos;
  logic signed [kop_pkg::POS_W-1:0]    y_pos;
  logic [kop_pkg::MMS_W-1:0]           anomaly_now;

  modport source (output valid, output x_pos, output y_pos, output anomaly_now, input ready);
  modport sink (input valid, input x_pos, input y_pos, input anomaly_now, output ready);
endinterface

// ===== hw/rtl/kop_cfg_if.sv =====
// configuration write channel
interface kop_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kop_pkg::CFG_IDX_W-1:0]     index;
  logic [kop_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/kepler_orbit_propagator.sv =====
// Kepler orbit propagator top level. Each tick item optionally advances the
// mean anomaly by the mean motion register, solves E - e*sin(E) = M by Newton
// iteration and returns the in-plane x and y position with the mean anomaly
// used. One item is in work at a time. Each Newton update is dominated by the
// 32-step CORDIC and the serial divider; the final position is mostly the
// CORDIC and the 32-step square root. The number of updates per tick is a
// handful at moderate eccentricity, at most MAX_ITERATIONS. Configuration
// writes are taken every cycle.
module kepler_orbit_propagator #(
  parameter int MAX_ITERATIONS     = kop_pkg::MAX_ITERATIONS_DEF,
  parameter int CONVERGE_TOLERANCE = kop_pkg::CONVERGE_TOLERANCE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  kop_tick_if.sink      tick,
  kop_result_if.source  result,
  kop_cfg_if.sink       cfg
);

  kop_pkg::dp_cmd_t cmd;
  kop_pkg::dp_sts_t sts;

  // sequencer
  kop_ctrl #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .in_ready (tick.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and registers
  kop_dpath #(
    .CONVERGE_TOLERANCE (CONVERGE_TOLERANCE)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .advance (tick.advance),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

// ===== hw/rtl/kop_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation per cycle
module kop_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] angle,
  output logic               busy,
  output logic signed [33:0] sin_q,
  output logic signed [33:0] cos_q
);

  localparam logic signed [33:0] QTR  = 34'sh0_4000_0000;
  localparam logic signed [33:0] HALF = 34'sh0_8000_0000;

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic               neg;
  logic [4:0]         cnt;

  logic signed [33:0] z_in;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;

  // angle taken modulo one turn as a signed fraction
  assign z_in = 34'(signed'(angle[31:0]));
  assign dx   = y >>> cnt;
  assign dy   = x >>> cnt;
  assign at   = signed'({2'b00, kop_pkg::atan_entry(cnt)});

  // rotation loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      x    <= signed'(kop_pkg::CORDIC_GAIN_Q30);
      y    <= '0;
      if (z_in > QTR) begin
        z   <= z_in - HALF;
        neg <= 1'b1;
      end else if (z_in < -QTR) begin
        z   <= z_in + HALF;
        neg <= 1'b1;
      end else begin
        z   <= z_in;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'(kop_pkg::CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // undo the half-turn fold
  assign sin_q = neg ? -y : y;
  assign cos_q = neg ? -x : x;

endmodule

// ===== hw/rtl/kop_div.sv =====
// restoring serial divider, one quotient bit per cycle
module kop_div #(
  parameter int NUM_W = 67,
  parameter int DEN_W = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [CNT_W-1:0] cnt;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  assign trial = {rem, sh[NUM_W-1]};
  assign diff  = trial - {1'b0, dv};
  assign qbit  = (trial >= {1'b0, dv});

  // shift in numerator bits, shift out quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      sh   <= num;
      rem  <= '0;
      dv   <= den;
    end else if (busy) begin
      rem <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh  <= {sh[NUM_W-2:0], qbit};
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = sh;

endmodule

// ===== hw/rtl/kop_dpath.sv =====
// datapath: registers, newton update, final position products and output register
module kop_dpath #(
  parameter int CONVERGE_TOLERANCE = kop_pkg::CONVERGE_TOLERANCE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  kop_pkg::dp_cmd_t   cmd,
  output kop_pkg::dp_sts_t   sts,
  input  logic               advance,
  kop_cfg_if.sink            cfg,
  kop_result_if.source       result
);

  localparam int MAG_W = 37;
  localparam int NUM_W = MAG_W + 30;
  localparam int DEN_W = 31;
  localparam logic [MAG_W-1:0] TOL = MAG_W'(CONVERGE_TOLERANCE);

  // configuration registers
  logic [kop_pkg::ECC_W-1:0] ecc;
  logic [kop_pkg::SMA_W-1:0] sma;
  logic [kop_pkg::MMS_W-1:0] mms;
  logic [31:0]               acc;

  // iteration datapath
  logic signed [33:0]  big;
  logic signed [33:0]  m;
  logic [15:0]         e_sat;
  logic signed [50:0]  prod_es;
  logic signed [50:0]  prod_ec;
  logic signed [65:0]  esin_p;
  logic signed [35:0]  esin;
  logic [DEN_W-1:0]    deriv;
  logic [MAG_W-1:0]    mag;
  logic                dneg;

  // final path
  logic signed [59:0]  xp;
  logic [31:0]         ee;
  logic [63:0]         sv;
  logic [63:0]         res;
  logic [4:0]          sq_k;
  logic                sq_busy;
  logic signed [65:0]  tp;
  logic signed [35:0]  tr;
  logic signed [60:0]  yp;
  logic                out_valid;

  // unit connections
  logic                cor_busy;
  logic signed [33:0]  s_q;
  logic signed [33:0]  c_q;
  logic                div_busy;
  logic [NUM_W-1:0]    quo;

  // combinational helpers
  logic [31:0]         acc_new;
  logic signed [34:0]  es_sh;
  logic signed [34:0]  ec_sh;
  logic signed [65:0]  esin_rnd;
  logic signed [35:0]  deriv_full;
  logic signed [37:0]  d;
  logic signed [68:0]  step_s;
  logic signed [68:0]  bn;
  logic signed [68:0]  win_hi;
  logic signed [68:0]  win_lo;
  logic signed [68:0]  bclamp;
  logic signed [24:0]  a_s;
  logic signed [34:0]  cm;
  logic [63:0]         sq_bit;
  logic [63:0]         sq_trial;
  logic signed [65:0]  tp_rnd;
  logic signed [59:0]  x_rnd;
  logic signed [60:0]  y_rnd;

  assign e_sat    = (ecc > kop_pkg::ECC_MAX) ? kop_pkg::ECC_MAX : ecc;
  assign m        = signed'({2'b00, acc});
  assign acc_new  = advance ? acc + mms : acc;
  assign es_sh    = prod_es[50:16];
  assign ec_sh    = prod_ec[50:16];
  assign esin_rnd = esin_p + 66'sd536870912;
  assign deriv_full = 36'sh0_4000_0000 - 36'(ec_sh);
  assign d        = 38'(big) - 38'(esin) - 38'(m);
  assign step_s   = signed'({2'b00, quo});
  assign bn       = dneg ? 69'(big) + step_s : 69'(big) - step_s;
  assign win_hi   = 69'(m) + 69'sd2147483648;
  assign win_lo   = 69'(m) - 69'sd2147483648;
  assign bclamp   = (bn > win_hi) ? win_hi : ((bn < win_lo) ? win_lo : bn);
  assign a_s      = signed'({1'b0, sma});
  assign cm       = 35'(c_q) - 35'(signed'({1'b0, e_sat, 14'b0}));
  assign sq_bit   = 64'd1 << {sq_k, 1'b0};
  assign sq_trial = res + sq_bit;
  assign tp_rnd   = tp + 66'sd536870912;
  assign x_rnd    = xp + 60'sd536870912;
  assign y_rnd    = yp + 61'sd536870912;

  // configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ecc <= kop_pkg::ECC_RESET;
      sma <= kop_pkg::SMA_RESET;
      mms <= kop_pkg::MMS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (kop_pkg::cfg_idx_t'(cfg.index))
        kop_pkg::CFG_ECC: ecc <= cfg.data[kop_pkg::ECC_W-1:0];
        kop_pkg::CFG_SMA: sma <= cfg.data[kop_pkg::SMA_W-1:0];
        kop_pkg::CFG_MMS: mms <= cfg.data[kop_pkg::MMS_W-1:0];
        default: ;
      endcase
    end
  end

  // mean anomaly accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.load) begin
      acc <= acc_new;
    end
  end

  // newton iterate and its intermediate products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      big <= signed'({2'b00, acc_new});
    end
    if (cmd.mul_es) begin
      prod_es <= signed'({1'b0, e_sat}) * s_q;
    end
    if (cmd.mul_inv) begin
      esin_p  <= es_sh * signed'(kop_pkg::INV_TWO_PI_Q32);
      prod_ec <= signed'({1'b0, e_sat}) * c_q;
    end
    if (cmd.esin) begin
      esin  <= esin_rnd[65:30];
      deriv <= deriv_full[DEN_W-1:0];
    end
    if (cmd.delta) begin
      mag  <= d[37] ? MAG_W'(-d) : d[MAG_W-1:0];
      dneg <= d[37];
    end
    if (cmd.update) begin
      big <= bclamp[33:0];
    end
  end

  // final position products
  always_ff @(posedge clk) begin
    if (cmd.fin_a) begin
      xp <= a_s * cm;
      ee <= e_sat * e_sat;
    end
    if (cmd.fin_t) begin
      tp <= signed'({1'b0, res[30:0]}) * s_q;
    end
    if (cmd.fin_tr) begin
      tr <= tp_rnd[65:30];
    end
    if (cmd.fin_y) begin
      yp <= a_s * tr;
    end
  end

  // digit-by-digit square root of (1 - e^2), operand in q60, root in q30
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_k    <= '0;
    end else if (cmd.sq_start) begin
      sq_busy <= 1'b1;
      sq_k    <= 5'd31;
      res     <= '0;
      sv      <= {3'b000, 33'(33'h1_0000_0000 - {1'b0, ee}), 28'b0};
    end else if (sq_busy) begin
      if (sv >= sq_trial) begin
        sv  <= sv - sq_trial;
        res <= (res >> 1) + sq_bit;
      end else begin
        res <= res >> 1;
      end
      sq_k <= sq_k - 5'd1;
      if (sq_k == 5'd0) begin
        sq_busy <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.x_pos       <= x_rnd[55:30];
      result.y_pos       <= y_rnd[55:30];
      result.anomaly_now <= acc;
    end
  end

  assign result.valid = out_valid;

  kop_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cor_start),
    .angle (big),
    .busy  (cor_busy),
    .sin_q (s_q),
    .cos_q (c_q)
  );

  kop_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({mag, 30'b0}),
    .den   (deriv),
    .busy  (div_busy),
    .quo   (quo)
  );

  // status to the controller
  assign sts.cor_busy  = cor_busy;
  assign sts.div_busy  = div_busy;
  assign sts.sq_busy   = sq_busy;
  assign sts.converged = (mag < TOL);
  assign sts.out_busy  = out_valid && !result.ready;

  // iterate stays within half a turn of the mean anomaly
  a_big_window: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.update) |-> (35'(big) <= 35'(m) + 35'sd2147483648) &&
                          (35'(big) >= 35'(m) - 35'sd2147483648))
    else $error("newton iterate left the half-turn window");

endmodule

// ===== hw/rtl/kop_ctrl.sv =====
// controller: sequences the newton loop and the final position computation
module kop_ctrl #(
  parameter int MAX_ITERATIONS = kop_pkg::MAX_ITERATIONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  kop_pkg::dp_sts_t sts,
  output kop_pkg::dp_cmd_t cmd
);

  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

  kop_pkg::state_t state;
  kop_pkg::state_t state_next;
  logic [ITER_W-1:0] iter;
  logic              final_pass;

  // state register, iteration count and final-pass flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kop_pkg::S_IDLE;
      iter       <= '0;
      final_pass <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        iter       <= '0;
        final_pass <= 1'b0;
      end else if (cmd.update) begin
        iter <= iter + 1'b1;
        if (iter == ITER_W'(MAX_ITERATIONS - 1)) begin
          final_pass <= 1'b1;
        end
      end
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      kop_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = kop_pkg::S_COR_GO;
        end
      end
      kop_pkg::S_COR_GO: begin
        cmd.cor_start = 1'b1;
        state_next    = kop_pkg::S_COR_WAIT;
      end
      kop_pkg::S_COR_WAIT: begin
        if (!sts.cor_busy) begin
          state_next = final_pass ? kop_pkg::S_FIN_A : kop_pkg::S_MUL_ES;
        end
      end
      kop_pkg::S_MUL_ES: begin
        cmd.mul_es = 1'b1;
        state_next = kop_pkg::S_MUL_INV;
      end
      kop_pkg::S_MUL_INV: begin
        cmd.mul_inv = 1'b1;
        state_next  = kop_pkg::S_ESIN;
      end
      kop_pkg::S_ESIN: begin
        cmd.esin   = 1'b1;
        state_next = kop_pkg::S_DELTA;
      end
      kop_pkg::S_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = kop_pkg::S_CHECK;
      end
      kop_pkg::S_CHECK: begin
        // converged: sine and cosine already belong to the current iterate
        state_next = sts.converged ? kop_pkg::S_FIN_A : kop_pkg::S_DIV_GO;
      end
      kop_pkg::S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = kop_pkg::S_DIV_WAIT;
      end
      kop_pkg::S_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = kop_pkg::S_UPDATE;
        end
      end
      kop_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = kop_pkg::S_COR_GO;
      end
      kop_pkg::S_FIN_A: begin
        cmd.fin_a  = 1'b1;
        state_next = kop_pkg::S_SQ_GO;
      end
      kop_pkg::S_SQ_GO: begin
        cmd.sq_start = 1'b1;
        state_next   = kop_pkg::S_SQ_WAIT;
      end
      kop_pkg::S_SQ_WAIT: begin
        if (!sts.sq_busy) begin
          state_next = kop_pkg::S_FIN_T;
        end
      end
      kop_pkg::S_FIN_T: begin
        cmd.fin_t  = 1'b1;
        state_next = kop_pkg::S_FIN_TR;
      end
      kop_pkg::S_FIN_TR: begin
        cmd.fin_tr = 1'b1;
        state_next = kop_pkg::S_FIN_Y;
      end
      kop_pkg::S_FIN_Y: begin
        cmd.fin_y  = 1'b1;
        state_next = kop_pkg::S_OUT;
      end
      kop_pkg::S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = kop_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kop_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == kop_pkg::S_IDLE && in_valid) |=> state == kop_pkg::S_COR_GO)
    else $error("accepted item did not start the solver");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= ITER_W'(MAX_ITERATIONS))
    else $error("newton update count past the limit");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("result written over an item not yet taken");

  a_converge_exit: assert property (@(posedge clk) disable iff (rst)
    (state == kop_pkg::S_CHECK && sts.converged) |=> state == kop_pkg::S_FIN_A)
    else $error("converged iterate was updated again");

endmodule
